>>> hdl/id3v24_tag_stream_parser_core_macros.svh
// ----------------------------------------------------------------------------
// id3v24_tag_stream_parser_core_macros.svh
// Assertion macros for the ID3v2.4 tag stream parser.
// ----------------------------------------------------------------------------
`ifndef ID3V24_TAG_STREAM_PARSER_CORE_MACROS_SVH
`define ID3V24_TAG_STREAM_PARSER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is asserted
`define ID3TP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("id3tp assertion failed");
// Clocked check, active during reset as well
`define ID3TP_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("id3tp assertion failed");
`else
`define ID3TP_ASSERT(lbl, clk, rst_n, prop)
`define ID3TP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> hdl/id3tp_pkg.sv
// ----------------------------------------------------------------------------
// id3tp_pkg
// Types, codes and helpers shared by the ID3v2.4 tag stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package id3tp_pkg;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_EXTHDR = 3'd1,
		PH_SKIP   = 3'd2,
		PH_FRAME  = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		EV_TAG_HDR   = 2'd0,
		EV_FRAME_HDR = 2'd1,
		EV_NO_HDR    = 2'd2,
		EV_TAG_END   = 2'd3
	} event_kind_t;

	localparam logic [7:0]  CHAR_I           = 8'h49;
	localparam logic [7:0]  CHAR_D           = 8'h44;
	localparam logic [7:0]  CHAR_3           = 8'h33;
	localparam logic [7:0]  MAJOR_V4         = 8'h04;
	localparam logic [7:0]  REV_INVALID      = 8'hFF;
	localparam int          EXT_FLAG_BIT     = 6;
	localparam logic [27:0] EXT_HDR_LEN      = 28'd6;
	localparam logic [3:0]  EXT_SIZE_BYTES   = 4'd4;
	localparam logic [3:0]  HDR_LAST_IDX     = 4'd9;
	localparam logic [15:0] SEARCH_LIMIT_RST = 16'd100;
	localparam int          WIN_DEPTH        = 9;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_item_t;

	typedef struct packed {
		event_kind_t event_kind;
		logic [7:0]  tag_revision;
		logic [7:0]  tag_flags;
		logic [27:0] tag_size;
		logic [31:0] frame_id;
		logic [27:0] frame_size;
		logic [15:0] frame_flags;
		logic [31:0] data_offset;
	} result_t;

	function automatic logic [27:0] syncsafe(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic [7:0] d);
		syncsafe = {a[6:0], b[6:0], c[6:0], d[6:0]};
	endfunction

endpackage

`default_nettype wire

>>> hdl/id3v24_tag_stream_parser_core.sv
// ----------------------------------------------------------------------------
// id3v24_tag_stream_parser_core
// Byte-stream parser for ID3v2.4 tag and frame headers.
//
//   channel   dir  fields (lsb first)
//   s_*       in   tdata: data_byte[7:0]; tuser: first_byte
//   m_*       out  tuser: event_kind[1:0]; tdata: see port comment
//   cfg_*     in   search_limit[15:0], write only
//
// One byte per cycle sustained while the result is not stalled; a byte's event
// is loaded into the result register after the input register and decode.
// Reset clears all parse state and loads search_limit with 100.
// A stalled result holds the input register, which then holds s_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module id3v24_tag_stream_parser_core #(
	parameter int POSITION_BITS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // data_byte[7:0]
	input  wire logic         s_tuser,   // first_byte
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// tag_revision[7:0], tag_flags[15:8], tag_size[43:16], frame_id[75:44],
	// frame_size[103:76], frame_flags[119:104], data_offset[151:120]
	output logic [151:0]      m_tdata,
	output logic [1:0]        m_tuser,   // event_kind[1:0]
	input  wire logic         cfg_we,
	input  wire logic [15:0]  cfg_wdata
);
	import id3tp_pkg::*;

	logic [15:0] limit_q;
	in_item_t    s_item, item_s1;
	logic        valid_s1, advance, out_free, res_valid;
	result_t     res, res_q;

	assign s_item  = '{data_byte: s_tdata, first_byte: s_tuser};
	assign advance = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= SEARCH_LIMIT_RST;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	id3tp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_item   (s_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	id3tp_parser #(
		.POSITION_BITS (POSITION_BITS)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.item         (item_s1),
		.search_limit (limit_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	id3tp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && res_valid),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res_q    (res_q)
	);

	assign m_tuser = res_q.event_kind;
	assign m_tdata = {res_q.data_offset, res_q.frame_flags, res_q.frame_size,
		res_q.frame_id, res_q.tag_size, res_q.tag_flags, res_q.tag_revision};

endmodule

`default_nettype wire

>>> hdl/id3tp_in_reg.sv
// ----------------------------------------------------------------------------
// id3tp_in_reg
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module id3tp_in_reg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire id3tp_pkg::in_item_t s_item,
	input  wire logic                advance,
	output logic                     valid_s1,
	output id3tp_pkg::in_item_t      item_s1
);
	import id3tp_pkg::*;

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= s_item;
		end
	end

endmodule

`default_nettype wire

>>> hdl/id3tp_parser.sv
// ----------------------------------------------------------------------------
// id3tp_parser
// Parse state and the per-byte decode: window search, extended header,
// body skip and frame header collection.
// ----------------------------------------------------------------------------
`default_nettype none
`include "id3v24_tag_stream_parser_core_macros.svh"

module id3tp_parser #(
	parameter int POSITION_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire id3tp_pkg::in_item_t item,
	input  wire logic [15:0]         search_limit,
	output logic                     res_valid,
	output id3tp_pkg::result_t       res
);
	import id3tp_pkg::*;

	localparam int PB  = POSITION_BITS;
	localparam int P1W = PB + 1;
	localparam int SW  = ((PB > 28) ? PB : 28) + 2;
	localparam int OW  = (P1W > 33) ? P1W : 33;
	localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

	phase_t      phase_q, ph_c, phase_n;
	logic [7:0]  win_q [WIN_DEPTH];
	logic [7:0]  win_c [WIN_DEPTH];
	logic [7:0]  win_sh [WIN_DEPTH];
	logic [7:0]  win_n [WIN_DEPTH];
	logic [PB-1:0] pos_q, pos_c, pos_n;
	logic [27:0] skip_q, skip_c, skip_n;
	logic [PB-1:0] tend_q, tend_c, tend_n;
	logic [3:0]  cnt_q, cnt_c, cnt_n, cnt_inc;

	logic [7:0]    b;
	logic [P1W-1:0] p1;
	logic [SW-1:0] tend_sum;
	logic [PB-1:0] tend_sat;
	logic [OW-1:0] off_wide;
	logic [31:0]   off_sat;
	logic          early, match, stop, at_end;
	logic [27:0]   tsize, fsize, skip_acc, skip_dec;

	// restart the parse on the first byte of a file
	always_comb begin
		ph_c   = item.first_byte ? PH_SEARCH : phase_q;
		pos_c  = item.first_byte ? '0 : pos_q;
		skip_c = item.first_byte ? '0 : skip_q;
		tend_c = item.first_byte ? '0 : tend_q;
		cnt_c  = item.first_byte ? '0 : cnt_q;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			win_c[i] = item.first_byte ? 8'h00 : win_q[i];
		end
		for (int i = 0; i < WIN_DEPTH - 1; i++) begin
			win_sh[i] = win_c[i + 1];
		end
		win_sh[WIN_DEPTH - 1] = item.data_byte;
	end

	assign b     = item.data_byte;
	assign p1    = P1W'(pos_c) + P1W'(1);
	assign early = pos_c < PB'(HDR_LAST_IDX);
	assign match = (pos_c < PB'(search_limit)) && (win_c[0] == CHAR_I) &&
		(win_c[1] == CHAR_D) && (win_c[2] == CHAR_3) && (win_c[3] == MAJOR_V4) &&
		(win_c[4] != REV_INVALID);
	assign stop  = p1 >= P1W'(search_limit);
	assign tsize = syncsafe(win_c[6], win_c[7], win_c[8], b);
	assign fsize = syncsafe(win_c[4], win_c[5], win_c[6], win_c[7]);

	assign tend_sum = SW'(p1) + SW'(tsize);
	assign tend_sat = (tend_sum > SW'(POS_MAX)) ? POS_MAX : tend_sum[PB-1:0];
	assign at_end   = p1 >= P1W'(tend_c);
	assign off_wide = OW'(p1);
	assign off_sat  = (off_wide > OW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : off_wide[31:0];

	assign cnt_inc  = cnt_c + 4'd1;
	assign skip_acc = (cnt_c < EXT_SIZE_BYTES) ? {skip_c[20:0], b[6:0]} : skip_c;
	assign skip_dec = (skip_c != '0) ? skip_c - 28'd1 : skip_c;

	// next state
	always_comb begin
		phase_n = ph_c;
		pos_n   = (pos_c == POS_MAX) ? pos_c : p1[PB-1:0];
		skip_n  = skip_c;
		tend_n  = tend_c;
		cnt_n   = cnt_c;
		win_n   = win_c;
		unique case (ph_c)
			PH_SEARCH: begin
				win_n = win_sh;
				if (!early) begin
					if (match) begin
						tend_n  = tend_sat;
						cnt_n   = '0;
						skip_n  = '0;
						phase_n = win_c[5][EXT_FLAG_BIT] ? PH_EXTHDR : PH_FRAME;
					end else if (stop) begin
						phase_n = PH_DONE;
					end
				end
			end
			PH_EXTHDR: begin
				if (cnt_inc >= 4'(EXT_HDR_LEN)) begin
					cnt_n = '0;
					if (skip_acc > EXT_HDR_LEN) begin
						skip_n  = skip_acc - EXT_HDR_LEN;
						phase_n = PH_SKIP;
					end else begin
						skip_n  = '0;
						phase_n = PH_FRAME;
					end
				end else begin
					cnt_n  = cnt_inc;
					skip_n = skip_acc;
				end
			end
			PH_SKIP: begin
				skip_n = skip_dec;
				if (skip_dec == '0) begin
					cnt_n   = '0;
					phase_n = PH_FRAME;
				end
			end
			PH_FRAME: begin
				win_n = win_sh;
				if (cnt_c < HDR_LAST_IDX) begin
					cnt_n = cnt_inc;
				end else begin
					cnt_n = '0;
					if (at_end) begin
						phase_n = PH_DONE;
					end else begin
						skip_n  = fsize;
						phase_n = (fsize != '0) ? PH_SKIP : PH_FRAME;
					end
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// result for this byte
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		unique case (ph_c)
			PH_SEARCH: begin
				if (!early) begin
					if (match) begin
						res_valid        = 1'b1;
						res.event_kind   = EV_TAG_HDR;
						res.tag_revision = win_c[4];
						res.tag_flags    = win_c[5];
						res.tag_size     = tsize;
					end else if (stop) begin
						res_valid      = 1'b1;
						res.event_kind = EV_NO_HDR;
					end
				end
			end
			PH_FRAME: begin
				if (cnt_c >= HDR_LAST_IDX) begin
					res_valid = 1'b1;
					if (at_end) begin
						res.event_kind = EV_TAG_END;
					end else begin
						res.event_kind  = EV_FRAME_HDR;
						res.frame_id    = {win_c[0], win_c[1], win_c[2], win_c[3]};
						res.frame_size  = fsize;
						res.frame_flags = {win_c[8], b};
						res.data_offset = off_sat;
					end
				end
			end
			PH_EXTHDR, PH_SKIP, PH_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			pos_q   <= '0;
			skip_q  <= '0;
			tend_q  <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= 8'h00;
			end
		end else if (advance) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			skip_q  <= skip_n;
			tend_q  <= tend_n;
			cnt_q   <= cnt_n;
			win_q   <= win_n;
		end
	end

	`ID3TP_ASSERT(a_done_holds, clk, arst_n, (phase_q == PH_DONE && !(advance && item.first_byte)) |=> (phase_q == PH_DONE))
	`ID3TP_ASSERT(a_skip_nonzero, clk, arst_n, (phase_q == PH_SKIP) |-> (skip_q != '0))
	`ID3TP_ASSERT(a_ext_count, clk, arst_n, (phase_q == PH_EXTHDR) |-> (cnt_q < 4'(EXT_HDR_LEN)))
	`ID3TP_ASSERT(a_frame_count, clk, arst_n, cnt_q <= HDR_LAST_IDX)

endmodule

`default_nettype wire

>>> hdl/id3tp_out_reg.sv
// ----------------------------------------------------------------------------
// id3tp_out_reg
// Result register: holds one event until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module id3tp_out_reg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire id3tp_pkg::result_t res,
	output logic                    free,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output id3tp_pkg::result_t      res_q
);
	import id3tp_pkg::*;

	// free when empty or being drained this cycle
	assign free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (free) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire
